// ===== sv/spq_pkg.sv =====
// spq_pkg: shared constants, operation and status codes, and the cell control struct
// for the sorted priority queue. No dependencies; used by spq_cell and sorted_priority_queue.

package spq_pkg;

   // storage geometry
   localparam int DEPTH     = 128;
   localparam int PRIO_BITS = 8;
   localparam int ITEM_W    = 32;
   localparam int COUNT_W   = $clog2(DEPTH + 1);

   // match reduction: groups of cells are or-ed first, then the group results
   localparam int GRP_SIZE  = 16;
   localparam int NGRP      = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

   // operation codes carried on req_tuser
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;

   // status codes carried on rsp_tuser
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                 ins;
      logic                 rem;
      logic                 srch;
      logic [ITEM_W-1:0]    item;
      logic [PRIO_BITS-1:0] prio;
   } cell_ctl_type;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// sorted_priority_queue: top level; controller, occupancy count, match reduction and
// result registers around a chain of spq_cell. Depends on spq_pkg and spq_cell.
//
//  channel   direction  handshake               payload
//  req       in         req_tvalid/req_tready   tuser mode, tdata item, priority_req
//  rsp       out        rsp_tvalid/rsp_tready   tuser status, tdata item, prio, found, count
//  csr       in         csr_valid/csr_ready     csr_data capacity
//
// Insert, remove and no-op go straight to the pending result; a search of a non-empty queue
// first passes the cell compare, group or and final or of the two-level match reduction.
// One transaction is in the chain at a time; a pending result register and the output
// register let the next transaction be taken while a result waits for rsp_tready.
// Synchronous reset empties the queue and sets capacity to 128; entries are not cleared.

module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [39:0] req_tdata,   // [31:0] item, [39:32] priority_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [55:0] rsp_tdata,   // [31:0] out_item, [39:32] out_priority, [40] found,
                                    // [48:41] count, [55:49] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_OR1  = 2'd1;
   localparam logic [1:0] ST_OR2  = 2'd2;

   localparam int DEPTH  = spq_pkg::DEPTH;
   localparam int CW     = spq_pkg::COUNT_W;
   localparam int PW     = spq_pkg::PRIO_BITS;
   localparam int IW     = spq_pkg::ITEM_W;
   localparam int NGRP   = spq_pkg::NGRP;
   localparam int GSIZE  = spq_pkg::GRP_SIZE;

   logic [1:0]    state_ff, state_in;
   logic [7:0]    capacity_ff, capacity_in;
   logic [CW-1:0] count_ff, count_in;

   logic          pend_valid_ff, pend_valid_in;
   logic [1:0]    pend_status_ff, pend_status_in;
   logic [IW-1:0] pend_item_ff, pend_item_in;
   logic [PW-1:0] pend_prio_ff, pend_prio_in;
   logic          pend_found_ff, pend_found_in;
   logic [CW-1:0] pend_count_ff, pend_count_in;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff;
   logic [IW-1:0] out_item_ff;
   logic [PW-1:0] out_prio_ff;
   logic          out_found_ff;
   logic [CW-1:0] out_count_ff;

   logic [NGRP-1:0] grp_ff;
   logic [NGRP-1:0] grp_in;

   logic [1:0]    mode;
   logic [IW-1:0] req_item;
   logic [PW-1:0] req_prio;
   logic          accept, pend_move, pend_write, full, empty;

   spq_pkg::cell_ctl_type ctl;

   logic [IW-1:0]         item_w [DEPTH];
   logic [PW-1:0]         prio_w [DEPTH];
   logic [DEPTH-1:0]      lt_w;
   logic [NGRP*GSIZE-1:0] match_w;

   assign mode     = req_tuser;
   assign req_item = req_tdata[31:0];
   assign req_prio = PW'(req_tdata[39:32]);

   // handshake
   assign pend_move  = pend_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE) && (!pend_valid_ff || pend_move);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // occupancy
   assign empty = (count_ff == '0);
   assign full  = (32'(count_ff) >= 32'(capacity_ff)) || (32'(count_ff) >= DEPTH);

   // broadcast to the cells
   always_comb begin
      ctl.ins  = accept && (mode == spq_pkg::MODE_INSERT) && !full;
      ctl.rem  = accept && (mode == spq_pkg::MODE_REMOVE) && !empty;
      ctl.srch = accept && (mode == spq_pkg::MODE_SEARCH);
      ctl.item = req_item;
      ctl.prio = req_prio;
   end

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic          occ;
      logic          p_lt;
      logic [IW-1:0] p_item, n_item;
      logic [PW-1:0] p_prio, n_prio;

      assign occ = (32'(count_ff) > i);

      if (i == 0) begin : g_first
         assign p_lt   = 1'b1;
         assign p_item = req_item;
         assign p_prio = req_prio;
      end else begin : g_mid
         assign p_lt   = lt_w[i-1];
         assign p_item = item_w[i-1];
         assign p_prio = prio_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign n_item = item_w[i];
         assign n_prio = prio_w[i];
      end else begin : g_inner
         assign n_item = item_w[i+1];
         assign n_prio = prio_w[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occ       (occ),
         .prev_lt   (p_lt),
         .prev_item (p_item),
         .prev_prio (p_prio),
         .next_item (n_item),
         .next_prio (n_prio),
         .item_out  (item_w[i]),
         .prio_out  (prio_w[i]),
         .lt_out    (lt_w[i]),
         .match_out (match_w[i])
      );
   end

   if (NGRP * GSIZE > DEPTH) begin : g_pad
      assign match_w[NGRP*GSIZE-1:DEPTH] = '0;
   end

   // first level of the match reduction
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = |match_w[g*GSIZE +: GSIZE];
      end
   end

   // count and sequencing
   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CW'(1);
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.srch && !empty) begin
               state_in = ST_OR1;
            end
         end
         ST_OR1: begin
            state_in = ST_OR2;
         end
         ST_OR2: begin
            if (!pend_valid_ff || pend_move) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pending result
   always_comb begin
      pend_write     = 1'b0;
      pend_status_in = pend_status_ff;
      pend_item_in   = pend_item_ff;
      pend_prio_in   = pend_prio_ff;
      pend_found_in  = pend_found_ff;
      pend_count_in  = pend_count_ff;

      if (state_ff == ST_OR2) begin
         if (!pend_valid_ff || pend_move) begin
            pend_write     = 1'b1;
            pend_status_in = spq_pkg::STAT_DONE;
            pend_item_in   = '0;
            pend_prio_in   = '0;
            pend_found_in  = |grp_ff;
            pend_count_in  = count_ff;
         end
      end else if (accept && !(ctl.srch && !empty)) begin
         pend_write     = 1'b1;
         pend_status_in = spq_pkg::STAT_DONE;
         pend_item_in   = '0;
         pend_prio_in   = '0;
         pend_found_in  = 1'b0;
         pend_count_in  = count_in;
         case (mode)
            spq_pkg::MODE_INSERT: begin
               if (full) begin
                  pend_status_in = spq_pkg::STAT_FULL;
               end
            end
            spq_pkg::MODE_REMOVE: begin
               if (empty) begin
                  pend_status_in = spq_pkg::STAT_EMPTY;
               end else begin
                  pend_item_in = item_w[0];
                  pend_prio_in = prio_w[0];
               end
            end
            spq_pkg::MODE_SEARCH: begin
               pend_status_in = spq_pkg::STAT_EMPTY;
            end
            default: begin
               pend_status_in = spq_pkg::STAT_DONE;
            end
         endcase
      end

      pend_valid_in = pend_write || (pend_valid_ff && !pend_move);
      out_valid_in  = pend_move || (out_valid_ff && !rsp_tready);
   end

   // configuration
   assign capacity_in = csr_valid ? csr_data : capacity_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         capacity_ff   <= 8'd128;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      grp_ff         <= grp_in;
      pend_status_ff <= pend_status_in;
      pend_item_ff   <= pend_item_in;
      pend_prio_ff   <= pend_prio_in;
      pend_found_ff  <= pend_found_in;
      pend_count_ff  <= pend_count_in;
      if (pend_move) begin
         out_status_ff <= pend_status_ff;
         out_item_ff   <= pend_item_ff;
         out_prio_ff   <= pend_prio_ff;
         out_found_ff  <= pend_found_ff;
         out_count_ff  <= pend_count_ff;
      end
   end

   // result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[31:0]  = out_item_ff;
      rsp_tdata[39:32] = 8'(out_prio_ff);
      rsp_tdata[40]    = out_found_ff;
      rsp_tdata[48:41] = 8'(out_count_ff);
   end

endmodule

// ===== sv/spq_cell.sv =====
// spq_cell: one position of the sorted chain; holds one entry, shifts toward its
// neighbors on insert and remove, and records a key match. Depends on spq_pkg.

module spq_cell (
   input  logic                          clock,
   input  spq_pkg::cell_ctl_type         ctl,
   input  logic                          occ,
   input  logic                          prev_lt,
   input  logic [spq_pkg::ITEM_W-1:0]    prev_item,
   input  logic [spq_pkg::PRIO_BITS-1:0] prev_prio,
   input  logic [spq_pkg::ITEM_W-1:0]    next_item,
   input  logic [spq_pkg::PRIO_BITS-1:0] next_prio,
   output logic [spq_pkg::ITEM_W-1:0]    item_out,
   output logic [spq_pkg::PRIO_BITS-1:0] prio_out,
   output logic                          lt_out,
   output logic                          match_out
);

   logic [spq_pkg::ITEM_W-1:0]    item_ff, item_in;
   logic [spq_pkg::PRIO_BITS-1:0] prio_ff, prio_in;
   logic                          match_ff, match_in;

   // entry stays in place on insert when it sorts strictly ahead of the new one
   assign lt_out = occ && (prio_ff < ctl.prio);

   // next entry: keep, take the new entry, take from the left, or take from the right
   always_comb begin
      item_in = item_ff;
      prio_in = prio_ff;
      if (ctl.ins && !lt_out) begin
         if (prev_lt) begin
            item_in = ctl.item;
            prio_in = ctl.prio;
         end else begin
            item_in = prev_item;
            prio_in = prev_prio;
         end
      end else if (ctl.rem) begin
         item_in = next_item;
         prio_in = next_prio;
      end
   end

   // key compare, captured when a search is accepted
   assign match_in = ctl.srch ? (occ && (item_ff == ctl.item)) : match_ff;

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      prio_ff  <= prio_in;
      match_ff <= match_in;
   end

   assign item_out  = item_ff;
   assign prio_out  = prio_ff;
   assign match_out = match_ff;

endmodule
